>>> src/sensor_frame_crc_check_and_scale_core_macros.svh
// Assertion macros used by the checker file of the sensor frame core.
`ifndef SENSOR_FRAME_CRC_CHECK_AND_SCALE_CORE_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_AND_SCALE_CORE_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define SFCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define SFCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/sfcs_pkg.sv
// Shared types and constants of the sensor frame check and scale core.
package sfcs_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Position of the next byte within the six-byte frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  // Checked raw words of one frame.
  typedef struct packed {
    logic [15:0] raw_t;
    logic [15:0] raw_rh;
    logic        ok;
  } frame_word_t;

  // Scaled result of one frame.
  typedef struct packed {
    logic signed [14:0] temperature_x100;
    logic [13:0]        humidity_x100;
    logic               status;
  } result_t;

endpackage

>>> src/sensor_frame_crc_check_and_scale_core.sv
// Top level of the sensor frame CRC check and scale core.
//
//   channel  direction  tdata (low bit up)                          tuser
//   s_axis   in         frame_byte[7:0]                             frame_restart
//   m_axis   out        temperature_x100[14:0], humidity_x100[13:0],  status
//                       zero pad to 32 bits
//
// One byte is taken every cycle while s_axis_tready is high; its CRC-8 step is done
// in the cycle it is taken. The sixth byte of a frame yields one result, which passes
// the frame register, the constant-multiply register, then divide, offset and clamp
// into the output register.
// Reset clears the byte position, the running checksum and all pipeline valid flags.
// A result held by a stalled m_axis fills the pipeline; s_axis stops only once all
// three result stages are full.
module sensor_frame_crc_check_and_scale_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tuser,   // [0] frame_restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_x100, [28:15] humidity_x100
  output logic        m_axis_tuser    // [0] status
);
  import sfcs_pkg::*;

  frame_word_t word;
  logic        word_valid, word_ready;
  result_t     res;

  sfcs_frame_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .restart_i    (s_axis_tuser),
    .byte_ready_o (s_axis_tready),
    .word_valid_o (word_valid),
    .word_o       (word),
    .word_ready_i (word_ready)
  );

  sfcs_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .word_ready_o (word_ready),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'b0, res.humidity_x100, res.temperature_x100};
  assign m_axis_tuser = res.status;

endmodule

>>> src/sfcs_frame_rx.sv
// Frame byte counter, CRC-8 check and raw word capture.
module sfcs_frame_rx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 restart_i,
  output logic                 byte_ready_o,
  output logic                 word_valid_o,
  output sfcs_pkg::frame_word_t word_o,
  input  logic                 word_ready_i
);
  import sfcs_pkg::*;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  pos_e        pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] held_q, held_d;
  logic        first_ok_q, first_ok_d;
  logic        emit;
  frame_word_t word_d, word_q;
  logic        word_valid_q;
  logic        acc;

  assign byte_ready_o = !word_valid_q || word_ready_i;
  assign acc          = byte_valid_i && byte_ready_o;
  assign pos_eff      = restart_i ? POS_T_HI : pos_q;

  // Next position.
  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      unique case (pos_eff)
        POS_T_HI:  pos_d = POS_T_LO;
        POS_T_LO:  pos_d = POS_T_CRC;
        POS_T_CRC: pos_d = POS_H_HI;
        POS_H_HI:  pos_d = POS_H_LO;
        POS_H_LO:  pos_d = POS_H_CRC;
        POS_H_CRC: pos_d = POS_T_HI;
        default:   pos_d = POS_T_LO;
      endcase
    end
  end

  // Checksum, held bytes and frame result.
  always_comb begin
    crc_d      = crc_q;
    held_d     = held_q;
    first_ok_d = first_ok_q;
    emit       = 1'b0;
    word_d.raw_t  = held_q[31:16];
    word_d.raw_rh = held_q[15:0];
    word_d.ok     = first_ok_q && (byte_i == crc_q);
    if (acc) begin
      unique case (pos_eff)
        POS_T_LO, POS_H_LO: begin
          crc_d  = crc8_step(crc_q, byte_i);
          held_d = {held_q[23:0], byte_i};
        end
        POS_T_CRC: begin
          first_ok_d = (byte_i == crc_q);
          crc_d      = CRC_INIT;
        end
        POS_H_CRC: begin
          emit       = 1'b1;
          crc_d      = CRC_INIT;
          first_ok_d = 1'b0;
        end
        default: begin
          // first byte of a word; unused codes restart the frame as well
          crc_d  = crc8_step(CRC_INIT, byte_i);
          held_d = {held_q[23:0], byte_i};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_T_HI;
      crc_q        <= CRC_INIT;
      first_ok_q   <= 1'b0;
      word_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      first_ok_q <= first_ok_d;
      if (byte_ready_o) begin
        word_valid_q <= acc && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (acc && emit) begin
      word_q <= word_d;
    end
  end

  assign word_valid_o = word_valid_q;
  assign word_o       = word_q;

endmodule

>>> src/sfcs_scale.sv
// Two-stage scaling of the raw words: constant multiply, then divide, offset and clamp.
module sfcs_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  word_valid_i,
  input  sfcs_pkg::frame_word_t word_i,
  output logic                  word_ready_o,
  output logic                  res_valid_o,
  output sfcs_pkg::result_t     res_o,
  input  logic                  res_ready_i
);
  import sfcs_pkg::*;

  localparam logic [30:0]        TempScale = 31'd17500;
  localparam logic [30:0]        HumScale  = 31'd12500;
  localparam logic [30:0]        RoundBias = 31'd32767;
  localparam logic signed [15:0] TempOffs  = 16'sd4500;
  localparam logic [13:0]        HumOffs   = 14'd600;
  localparam logic [13:0]        HumMax    = 14'd10000;

  logic        prod_valid_q;
  logic [30:0] prod_t_q, prod_h_q;
  logic        prod_ok_q;
  logic        out_valid_q;
  result_t     res_d, res_q;
  logic        ready_out, ready_prod;

  logic [31:0]        sum_t, sum_h;
  logic [14:0]        q_t;
  logic [13:0]        q_h, h_sub;
  logic signed [15:0] t_full;

  assign ready_out    = !out_valid_q || res_ready_i;
  assign ready_prod   = !prod_valid_q || ready_out;
  assign word_ready_o = ready_prod;

  // x / 65535 as (x + (x >> 16) + 1) >> 16, exact while the quotient fits 16 bits.
  always_comb begin
    sum_t  = {1'b0, prod_t_q} + {17'b0, prod_t_q[30:16]} + 32'd1;
    sum_h  = {1'b0, prod_h_q} + {17'b0, prod_h_q[30:16]} + 32'd1;
    q_t    = sum_t[30:16];
    q_h    = sum_h[29:16];
    t_full = $signed({1'b0, q_t}) - TempOffs;
    h_sub  = q_h - HumOffs;
    res_d.status           = !prod_ok_q;
    res_d.temperature_x100 = '0;
    res_d.humidity_x100    = '0;
    if (prod_ok_q) begin
      res_d.temperature_x100 = t_full[14:0];
      priority if (q_h < HumOffs) begin
        res_d.humidity_x100 = '0;
      end else if (h_sub > HumMax) begin
        res_d.humidity_x100 = HumMax;
      end else begin
        res_d.humidity_x100 = h_sub;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ready_prod) begin
        prod_valid_q <= word_valid_i;
      end
      if (ready_out) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_prod && word_valid_i) begin
      prod_t_q  <= {15'b0, word_i.raw_t} * TempScale + RoundBias;
      prod_h_q  <= {15'b0, word_i.raw_rh} * HumScale + RoundBias;
      prod_ok_q <= word_i.ok;
    end
    if (ready_out && prod_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/sfcs_checker.sv
// Port-level checks of the sensor frame core and their bind.
`include "sensor_frame_crc_check_and_scale_core_macros.svh"

module sfcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [13:0]        hum_x100;
  logic signed [14:0] temp_x100;
  logic               range_ok;
  logic               err_shown;
  logic               out_stall;
  logic [32:0]        out_word;

  assign hum_x100  = m_axis_tdata[28:15];
  assign temp_x100 = $signed(m_axis_tdata[14:0]);
  assign range_ok  = (hum_x100 <= 14'd10000) && (temp_x100 >= -15'sd4500) &&
                     (temp_x100 <= 15'sd13000) && (m_axis_tdata[31:29] == 3'd0);
  assign err_shown = m_axis_tvalid && m_axis_tuser;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  `SFCS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

  `SFCS_ASSERT(a_error_zero, err_shown |-> (m_axis_tdata == 32'd0), "error result not zero")

  `SFCS_ASSERT(a_range, m_axis_tvalid |-> range_ok, "result out of range")

  `SFCS_ASSERT(a_out_hold, out_stall |=> (m_axis_tvalid && $stable(out_word)), "stalled result changed")

endmodule

bind sensor_frame_crc_check_and_scale_core sfcs_checker u_sfcs_checker (.*);
